[hdl/grid_pattern_chain_counter_core_macros.svh]
// assertion macros for the grid pattern chain counter core
// uses the clk and rst_n names of the module that expands them
`ifndef GRID_PATTERN_CHAIN_COUNTER_CORE_MACROS_SVH
`define GRID_PATTERN_CHAIN_COUNTER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define GPCC_ASSERT_IMPLIES(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("gpcc same-cycle check failed");

// next-cycle implication, checked out of reset
`define GPCC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("gpcc next-cycle check failed");

`endif

[hdl/gpcc_pkg.sv]
// shared types and constants for the grid pattern chain counter
// no dependencies
package gpcc_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_SYMBOL  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIDDLE_SYMBOL = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FINAL_SYMBOL  = 8'd3;

    // register reset values
    localparam logic [8:0] ROW_LENGTH_RESET    = 9'd256;
    localparam logic [7:0] FIRST_SYMBOL_RESET  = 8'd58;
    localparam logic [7:0] MIDDLE_SYMBOL_RESET = 8'd45;
    localparam logic [7:0] FINAL_SYMBOL_RESET  = 8'd41;

    // queue between front and back, depth a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // role a cell plays in a chain
    typedef enum logic [1:0] {
        ROLE_NONE,
        ROLE_FIRST,
        ROLE_MIDDLE,
        ROLE_FINAL
    } role_t;

    // classified cell, without its column
    typedef struct packed {
        role_t role;
        logic  first_row;
        logic  last;
    } cell_info_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic fire_last;
    } back_stat_t;

endpackage

[hdl/gpcc_front.sv]
// front end: configuration registers, cell classification, column tracking
// depends on gpcc_pkg
module gpcc_front #(
    parameter int MAX_COLS = 256,
    parameter int CW       = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gpcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [8:0]                        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        in_symbol,
    input  logic                              in_last,
    input  gpcc_pkg::queue_stat_t             q_stat,
    output logic                              push,
    output logic [CW+$bits(gpcc_pkg::cell_info_t)-1:0] push_data
);

    localparam int LW   = $clog2(MAX_COLS + 1);
    localparam int CMPW = (LW > 9) ? LW : 9;

    logic [8:0]    row_length_reg;
    logic [7:0]    first_symbol_reg;
    logic [7:0]    middle_symbol_reg;
    logic [7:0]    final_symbol_reg;
    logic [CW-1:0] col_reg, col_next;
    logic          first_row_reg, first_row_next;

    logic [CMPW-1:0]      eff_len;
    logic [CMPW-1:0]      col_plus;
    logic                 accept;
    gpcc_pkg::cell_info_t info;

    // configuration writes, always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg    <= gpcc_pkg::ROW_LENGTH_RESET;
            first_symbol_reg  <= gpcc_pkg::FIRST_SYMBOL_RESET;
            middle_symbol_reg <= gpcc_pkg::MIDDLE_SYMBOL_RESET;
            final_symbol_reg  <= gpcc_pkg::FINAL_SYMBOL_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gpcc_pkg::REG_ROW_LENGTH:    row_length_reg    <= cfg_data;
                gpcc_pkg::REG_FIRST_SYMBOL:  first_symbol_reg  <= cfg_data[7:0];
                gpcc_pkg::REG_MIDDLE_SYMBOL: middle_symbol_reg <= cfg_data[7:0];
                gpcc_pkg::REG_FINAL_SYMBOL:  final_symbol_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input handshake
    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    // effective row length: zero counts as one, clamp to the line buffer size
    always_comb
    begin
        if (row_length_reg == 9'd0)
            eff_len = CMPW'(1);
        else if (CMPW'(row_length_reg) > CMPW'(MAX_COLS))
            eff_len = CMPW'(MAX_COLS);
        else
            eff_len = CMPW'(row_length_reg);
    end

    assign col_plus = CMPW'(col_reg) + CMPW'(1);

    // column and first-row tracking
    always_comb
    begin
        col_next       = col_reg;
        first_row_next = first_row_reg;
        if (accept)
        begin
            if (in_last)
            begin
                col_next       = '0;
                first_row_next = 1'b1;
            end
            else if (col_plus >= eff_len)
            begin
                col_next       = '0;
                first_row_next = 1'b0;
            end
            else
            begin
                col_next = col_plus[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
        end
        else
        begin
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
        end
    end

    // role decode, first match wins
    always_comb
    begin
        if (in_symbol == first_symbol_reg)
            info.role = gpcc_pkg::ROLE_FIRST;
        else if (in_symbol == middle_symbol_reg)
            info.role = gpcc_pkg::ROLE_MIDDLE;
        else if (in_symbol == final_symbol_reg)
            info.role = gpcc_pkg::ROLE_FINAL;
        else
            info.role = gpcc_pkg::ROLE_NONE;
        info.first_row = first_row_reg;
        info.last      = in_last;
    end

    assign push      = accept;
    assign push_data = {col_reg, info};

endmodule

[hdl/gpcc_queue.sv]
// short queue of classified cells between front and back
// depends on gpcc_pkg
module gpcc_queue #(
    parameter int W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [W-1:0]          push_data,
    input  logic                  pop,
    output logic                  pop_valid,
    output logic [W-1:0]          pop_data,
    output gpcc_pkg::queue_stat_t stat
);

    logic [W-1:0]                slots_reg [gpcc_pkg::QUEUE_DEPTH];
    logic [gpcc_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [gpcc_pkg::QPTR_W:0]   count_reg, count_next;
    logic                        do_push, do_pop;

    assign stat.full  = (count_reg == (gpcc_pkg::QPTR_W+1)'(gpcc_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_valid  = !stat.empty;
    assign pop_data   = slots_reg[rd_ptr_reg];

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (gpcc_pkg::QPTR_W+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (gpcc_pkg::QPTR_W+1)'(1);
    end

    // pointers wrap at the power-of-two depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + (gpcc_pkg::QPTR_W)'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + (gpcc_pkg::QPTR_W)'(1);
            count_reg <= count_next;
        end
    end

endmodule

[hdl/gpcc_back.sv]
// back end: prefix-sum line buffers, neighbor registers, total and result register
// depends on gpcc_pkg
module gpcc_back #(
    parameter int MAX_COLS = 256,
    parameter int CW       = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  logic [CW+$bits(gpcc_pkg::cell_info_t)-1:0] q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           out_data,
    output gpcc_pkg::back_stat_t  stat
);

    localparam int INFO_W = $bits(gpcc_pkg::cell_info_t);

    // line buffers
    logic [31:0] start_mem   [MAX_COLS];
    logic [31:0] partial_mem [MAX_COLS];

    logic [31:0] start_rd_reg, partial_rd_reg;
    logic [31:0] fwd_s_reg, fwd_p_reg;
    logic        fwd_reg;

    logic                 b_valid_reg;
    logic [CW-1:0]        b_col_reg;
    gpcc_pkg::cell_info_t b_info_reg;

    logic [31:0] left_s_reg, left_p_reg, diag_s_reg, diag_p_reg;
    logic [31:0] total_reg, total_next;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic [CW-1:0] q_col;
    logic          b_fire, b_load;
    logic [31:0]   up_s, up_p, lf_s, lf_p, dg_s, dg_p;
    logic [31:0]   new_s, new_p, add_p, total_sum;

    assign q_col = q_data[INFO_W +: CW];

    // stage handshake: only a last cell waits for the result register
    assign b_fire = b_valid_reg &&
                    (!b_info_reg.last || !out_valid_reg || out_ready);
    assign b_load = q_valid && (!b_valid_reg || b_fire);
    assign q_pop  = b_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            if (b_load)
            begin
                b_valid_reg <= 1'b1;
                // a write to the column being read lands in the same cycle
                fwd_reg     <= b_fire && (b_col_reg == q_col);
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_col_reg  <= q_col;
            b_info_reg <= gpcc_pkg::cell_info_t'(q_data[INFO_W-1:0]);
            fwd_s_reg  <= new_s;
            fwd_p_reg  <= new_p;
        end
    end

    // line buffer read and write ports
    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            start_mem[b_col_reg]   <= new_s;
            partial_mem[b_col_reg] <= new_p;
        end
        if (b_load)
        begin
            start_rd_reg   <= start_mem[q_col];
            partial_rd_reg <= partial_mem[q_col];
        end
    end

    // neighbor selection: zero above the first row and left of column zero
    always_comb
    begin
        up_s = '0;
        up_p = '0;
        if (!b_info_reg.first_row)
        begin
            up_s = fwd_reg ? fwd_s_reg : start_rd_reg;
            up_p = fwd_reg ? fwd_p_reg : partial_rd_reg;
        end
        lf_s = '0;
        lf_p = '0;
        dg_s = '0;
        dg_p = '0;
        if (b_col_reg != '0)
        begin
            lf_s = left_s_reg;
            lf_p = left_p_reg;
            dg_s = diag_s_reg;
            dg_p = diag_p_reg;
        end
    end

    // prefix sums for this cell
    always_comb
    begin
        new_s = up_s + lf_s - dg_s;
        new_p = up_p + lf_p - dg_p;
        add_p = '0;
        case (b_info_reg.role)
            gpcc_pkg::ROLE_FIRST:  new_s = new_s + 32'd1;
            gpcc_pkg::ROLE_MIDDLE: new_p = new_p + dg_s;
            gpcc_pkg::ROLE_FINAL:  add_p = dg_p;
            default: ;
        endcase
        total_sum  = total_reg + add_p;
        total_next = b_info_reg.last ? 32'd0 : total_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_s_reg <= '0;
            left_p_reg <= '0;
            diag_s_reg <= '0;
            diag_p_reg <= '0;
            total_reg  <= '0;
        end
        else if (b_fire)
        begin
            left_s_reg <= new_s;
            left_p_reg <= new_p;
            diag_s_reg <= up_s;
            diag_p_reg <= up_p;
            total_reg  <= total_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (b_fire && b_info_reg.last)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (b_fire && b_info_reg.last)
            out_data_reg <= total_sum;
    end

    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;
    assign stat.fire_last = b_fire && b_info_reg.last;

endmodule

[hdl/grid_pattern_chain_counter_core.sv]
// top level of the grid pattern chain counter
// depends on gpcc_pkg, gpcc_front, gpcc_queue, gpcc_back and the macros header

// Counts three-cell chains (first, middle, final symbol, each strictly down
// and right of the one before) over a grid streamed in raster order, and
// returns the count modulo 2^32 on the cell flagged by s_axis_tlast. One cell
// is taken every clock cycle when the result side keeps up; a grid's last
// cell passes the queue, back-end stage and result register. The rate is set
// by the line buffers, which make one read and one write per cycle, with
// same-column forwarding covering one-cell rows. The line buffers need no
// clearing after reset: the first row of every grid reads zeros in their place.
`include "grid_pattern_chain_counter_core_macros.svh"

module grid_pattern_chain_counter_core #(
    parameter int MAX_COLS = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gpcc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [8:0]                       cfg_data,
    // cell stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] symbol
    input  logic                             s_axis_tlast,  // last_cell
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [31:0]                      m_axis_tdata   // [31:0] chain_total
);

    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int QW     = CW + $bits(gpcc_pkg::cell_info_t);

    gpcc_pkg::queue_stat_t q_stat;
    gpcc_pkg::back_stat_t  back_stat;
    logic                  push, q_pop, q_valid;
    logic [QW-1:0]         push_data, q_data;

    // classify and track columns
    gpcc_front #(
        .MAX_COLS (MAX_COLS),
        .CW       (CW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_symbol (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // decoupling queue
    gpcc_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data),
        .stat      (q_stat)
    );

    // prefix sums and total
    gpcc_back #(
        .MAX_COLS (MAX_COLS),
        .CW       (CW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .stat      (back_stat)
    );

    // checks
    `GPCC_ASSERT_IMPLIES(a_ready_follows_queue, !s_axis_tready, q_stat.full)
    `GPCC_ASSERT_NEXT(a_last_gives_result, back_stat.fire_last, m_axis_tvalid)
    `GPCC_ASSERT_IMPLIES(a_result_has_cause, $rose(m_axis_tvalid), $past(back_stat.fire_last))

endmodule

[tb/tb_grid_pattern_chain_counter_core.sv]
// self-checking testbench for grid_pattern_chain_counter_core
// depends on gpcc_pkg and the core rtl; predicts each grid's chain total and
// compares it with every transfer on the result stream
`timescale 1ns / 1ps

module tb_grid_pattern_chain_counter_core;

    localparam int LINE_DEPTH = 256;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES = 20;
    // first register index the block does not implement
    localparam logic [7:0] REG_SPARE_FIRST = 8'd4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [8:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;  // [7:0] symbol
    logic        s_axis_tlast = 1'b0;  // last_cell
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;  // [31:0] chain_total

    grid_pattern_chain_counter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the configuration registers
    logic [8:0] row_len_reg;
    logic [7:0] sym_first;
    logic [7:0] sym_middle;
    logic [7:0] sym_final;

    // shadow copy of the prefix-sum state
    logic [31:0] start_sums [LINE_DEPTH];
    logic [31:0] chain_sums [LINE_DEPTH];
    logic [31:0] left_start;
    logic [31:0] left_chain;
    logic [31:0] diag_start;
    logic [31:0] diag_chain;
    int unsigned cell_col;
    bit          top_row;
    logic [31:0] grid_total;

    logic [31:0] totals_due [$];
    int unsigned fail_count = 0;
    int unsigned results_seen = 0;
    int unsigned grids_sent = 0;
    int unsigned cells_sent = 0;
    bit          quiet = 1'b0;

    // row length as the block applies it
    function automatic int unsigned eff_row_len();
        if (row_len_reg == 9'd0)
            return 1;
        if (row_len_reg > LINE_DEPTH)
            return LINE_DEPTH;
        return 32'(row_len_reg);
    endfunction

    // symbol mostly drawn from the configured roles so chains actually form
    function automatic logic [7:0] pick_symbol();
        case ($urandom_range(0, 7))
            0, 1: return sym_first;
            2, 3: return sym_middle;
            4, 5: return sym_final;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic reset_model();
        for (int i = 0; i < LINE_DEPTH; i++)
        begin
            start_sums[i] = '0;
            chain_sums[i] = '0;
        end
        left_start = '0;
        left_chain = '0;
        diag_start = '0;
        diag_chain = '0;
        cell_col = 0;
        top_row = 1'b1;
        grid_total = '0;
        row_len_reg = gpcc_pkg::ROW_LENGTH_RESET;
        sym_first = gpcc_pkg::FIRST_SYMBOL_RESET;
        sym_middle = gpcc_pkg::MIDDLE_SYMBOL_RESET;
        sym_final = gpcc_pkg::FINAL_SYMBOL_RESET;
    endtask

    // advance the prefix sums by one accepted cell
    task automatic predict_cell(input logic [7:0] sym, input logic last);
        int unsigned len;
        int unsigned c;
        logic [31:0] up_s, up_p, lf_s, lf_p, dg_s, dg_p, new_s, new_p;
        len = eff_row_len();
        c = cell_col;
        up_s = '0;
        up_p = '0;
        lf_s = '0;
        lf_p = '0;
        dg_s = '0;
        dg_p = '0;
        if (!top_row)
        begin
            up_s = start_sums[c];
            up_p = chain_sums[c];
        end
        if (c != 0)
        begin
            lf_s = left_start;
            lf_p = left_chain;
            dg_s = diag_start;
            dg_p = diag_chain;
        end
        new_s = up_s + lf_s - dg_s;
        new_p = up_p + lf_p - dg_p;
        // one role per cell, first symbol wins over middle over final
        if (sym == sym_first)
            new_s = new_s + 32'd1;
        else if (sym == sym_middle)
            new_p = new_p + dg_s;
        else if (sym == sym_final)
            grid_total = grid_total + dg_p;
        start_sums[c] = new_s;
        chain_sums[c] = new_p;
        left_start = new_s;
        left_chain = new_p;
        diag_start = up_s;
        diag_chain = up_p;
        if (c + 1 >= len)
        begin
            cell_col = 0;
            top_row = 1'b0;
            left_start = '0;
            left_chain = '0;
            diag_start = '0;
            diag_chain = '0;
        end
        else
            cell_col = c + 1;
        // grid end: emit and restart
        if (last)
        begin
            totals_due.push_back(grid_total);
            grid_total = '0;
            cell_col = 0;
            top_row = 1'b1;
            left_start = '0;
            left_chain = '0;
            diag_start = '0;
            diag_chain = '0;
        end
    endtask

    // one cell transfer; entered and left at a falling edge
    task automatic send_cell(input logic [7:0] sym, input logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= sym;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_cell(sym, last);
        cells_sent++;
        if (last)
            grids_sent++;
        @(negedge clk);
    endtask

    // stop the cell stream and wait until every expected total has come
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (totals_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one register transfer; leaves cfg_valid high for a following write
    task automatic write_reg(input logic [7:0] idx, input logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            gpcc_pkg::REG_ROW_LENGTH:    row_len_reg = val;
            gpcc_pkg::REG_FIRST_SYMBOL:  sym_first = val[7:0];
            gpcc_pkg::REG_MIDDLE_SYMBOL: sym_middle = val[7:0];
            gpcc_pkg::REG_FINAL_SYMBOL:  sym_final = val[7:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // write the selected registers while the block is idle
    // which: [0] row length, [1] first, [2] middle, [3] final, [4] unused index
    task automatic set_config(input logic [4:0] which, input logic [8:0] len,
                              input logic [7:0] f, input logic [7:0] m,
                              input logic [7:0] fin);
        settle();
        if (which[0])
            write_reg(gpcc_pkg::REG_ROW_LENGTH, len);
        // symbol registers ignore bit 8
        if (which[1])
            write_reg(gpcc_pkg::REG_FIRST_SYMBOL, {1'($urandom_range(0, 1)), f});
        if (which[2])
            write_reg(gpcc_pkg::REG_MIDDLE_SYMBOL, {1'($urandom_range(0, 1)), m});
        if (which[3])
            write_reg(gpcc_pkg::REG_FINAL_SYMBOL, {1'($urandom_range(0, 1)), fin});
        if (which[4])
            write_reg(8'($urandom_range(REG_SPARE_FIRST, 255)), 9'($urandom_range(0, 511)));
        cfg_valid <= 1'b0;
    endtask

    // result side: per result a random stall before tready rises
    int unsigned results_paced = 0;
    bit          hold_drawn = 1'b0;
    int          rx_hold = 0;

    always @(negedge clk)
    begin
        if (results_seen != results_paced)
        begin
            results_paced = results_seen;
            hold_drawn = 1'b0;
        end
        if (m_axis_tvalid === 1'b1 && !hold_drawn)
        begin
            hold_drawn = 1'b1;
            rx_hold = quiet ? 0 : $urandom_range(0, 4);
        end
        if (rx_hold > 0)
        begin
            rx_hold = rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // compare each result transfer with the oldest predicted total
    always @(posedge clk)
    begin : check_results
        logic [31:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (totals_due.size() == 0)
            begin
                $display("%0t: unexpected chain_total, expected none, actual %0d",
                         $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = totals_due.pop_front();
                if (m_axis_tdata !== want)
                begin
                    $display("%0t: chain_total mismatch, expected %0d, actual %0d",
                             $time, want, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    // reset register values with a short first-row grid
    task automatic test_reset_config();
        send_cell(gpcc_pkg::FIRST_SYMBOL_RESET, 1'b0);
        send_cell(gpcc_pkg::MIDDLE_SYMBOL_RESET, 1'b0);
        send_cell(gpcc_pkg::FINAL_SYMBOL_RESET, 1'b1);
        settle();
    endtask

    // one full diagonal chain in a 3x3 grid, extreme byte codes as filler
    task automatic test_basic_chain();
        logic [7:0] cells [9];
        cells = '{gpcc_pkg::FIRST_SYMBOL_RESET, 8'h00, 8'hFF,
                  8'h00, gpcc_pkg::MIDDLE_SYMBOL_RESET, 8'hFF,
                  8'hFF, 8'h00, gpcc_pkg::FINAL_SYMBOL_RESET};
        set_config(5'b00001, 9'd3, 8'h00, 8'h00, 8'h00);
        quiet = 1'b1;
        for (int i = 0; i < 9; i++)
            send_cell(cells[i], i == 8);
        quiet = 1'b0;
        settle();
    endtask

    // all three roles on one code: every cell counts only as a first symbol
    task automatic test_symbol_overlap();
        set_config(5'b01111, 9'd2, 8'hAA, 8'hAA, 8'hAA);
        for (int i = 0; i < 4; i++)
            send_cell(8'hAA, i == 3);
        settle();
    endtask

    // row length zero acts as one; a write to an unused index changes nothing
    task automatic test_row_length_bounds();
        set_config(5'b11111, 9'd0, gpcc_pkg::FIRST_SYMBOL_RESET,
                   gpcc_pkg::MIDDLE_SYMBOL_RESET, gpcc_pkg::FINAL_SYMBOL_RESET);
        send_cell(gpcc_pkg::FIRST_SYMBOL_RESET, 1'b0);
        send_cell(gpcc_pkg::MIDDLE_SYMBOL_RESET, 1'b0);
        send_cell(gpcc_pkg::FINAL_SYMBOL_RESET, 1'b1);
        // single-cell grid
        send_cell(gpcc_pkg::FIRST_SYMBOL_RESET, 1'b1);
        settle();
    endtask

    // full-width rows, a saturated row length and an odd one
    task automatic test_long_rows();
        logic [8:0] lens [3];
        int unsigned counts [3];
        lens = '{9'd256, 9'd511, 9'd255};
        counts = '{520, 260, 258};
        for (int k = 0; k < 3; k++)
        begin
            set_config(5'b01111, lens[k], 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            quiet = (k == 0);
            for (int i = 0; i < counts[k]; i++)
                send_cell(pick_symbol(), i == counts[k] - 1);
        end
        quiet = 1'b0;
        settle();
    endtask

    // many small grids with random settings, some back to back
    task automatic test_random_grids(input int unsigned item_target,
                                     input int unsigned grid_target);
        int unsigned start_cells;
        int unsigned start_grids;
        int unsigned rows;
        int unsigned n_cells;
        logic [8:0] len;
        logic [7:0] f, m, fin;
        logic [4:0] which;
        start_cells = cells_sent;
        start_grids = grids_sent;
        while (cells_sent - start_cells < item_target ||
               grids_sent - start_grids < grid_target)
        begin
            which = ($urandom_range(0, 3) == 0) ? 5'b00000 : 5'($urandom_range(1, 31));
            len = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(8, 16))
                                             : 9'($urandom_range(0, 7));
            f = 8'($urandom_range(0, 255));
            m = ($urandom_range(0, 5) == 0) ? f : 8'($urandom_range(0, 255));
            fin = ($urandom_range(0, 5) == 0) ? m : 8'($urandom_range(0, 255));
            if (which != 5'b00000)
                set_config(which, len, f, m, fin);
            quiet = ($urandom_range(0, 3) == 0);
            rows = $urandom_range(1, 5);
            n_cells = rows * eff_row_len();
            // some grids end partway through a row
            if ($urandom_range(0, 2) == 0)
                n_cells = $urandom_range(1, n_cells);
            for (int i = 0; i < n_cells; i++)
                send_cell(pick_symbol(), i == n_cells - 1);
        end
        quiet = 1'b0;
        settle();
    endtask

    // test sequence
    initial
    begin
        reset_model();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_config();
        test_basic_chain();
        test_symbol_overlap();
        test_row_length_bounds();
        test_long_rows();
        test_random_grids(700, 40);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("tb_grid_pattern_chain_counter_core: PASS");
        else
            $display("tb_grid_pattern_chain_counter_core: FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb_grid_pattern_chain_counter_core: FAIL");
        $finish;
    end

endmodule
